// File: hdl/rmwf_pkg.sv
`timescale 1ns / 1ps

package rmwf_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int WINDOW_DEF  = 5;
  localparam int MIDDLE_RANK = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

// File: hdl/rmwf_zmem.sv
`timescale 1ns / 1ps

module rmwf_zmem #(
  parameter int DEPTH = rmwf_pkg::WINDOW_DEF,
  parameter int WIDTH = rmwf_pkg::SAMPLE_W,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem_r[rd_addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/running_median_window_filter.sv
`timescale 1ns / 1ps
// Each request runs a removal pass and then an insertion pass over the sorted store, which has
// one read and one write port, one entry per cycle; in_stall holds off the next request
// until the result is registered.
// A finished result waits in the output register while the next request runs.
// Synchronous reset (rst_n low) clears the write position; both stores then read as zero.

module running_median_window_filter #(
  parameter int WINDOW = rmwf_pkg::WINDOW_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  rmwf_pkg::sample_t       in_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output rmwf_pkg::sample_t       out_median,
  output rmwf_pkg::sample_t       out_latest
);

  localparam int IW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int RANK = (rmwf_pkg::MIDDLE_RANK >= WINDOW) ? WINDOW - 1 : rmwf_pkg::MIDDLE_RANK;
  localparam int PEN  = (WINDOW > 1) ? WINDOW - 2 : 0;
  localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW - 1);
  localparam logic [IW-1:0] PEN_IDX  = IW'(PEN);
  localparam logic [IW-1:0] RANK_IDX = IW'(RANK);

  typedef enum logic [2:0] {
    ST_IDLE, ST_OLD, ST_DEL, ST_ISS, ST_INS, ST_LAST, ST_MED, ST_DONE
  } state_t;

  state_t            state_r;
  logic [IW-1:0]     pos_r;
  logic [IW-1:0]     cnt_r;
  rmwf_pkg::sample_t new_r;
  rmwf_pkg::sample_t old_r;
  rmwf_pkg::sample_t carry_r;
  logic              found_r;
  logic              ins_r;
  logic              out_valid_r;
  rmwf_pkg::sample_t out_median_r;
  rmwf_pkg::sample_t out_latest_r;

  logic              acc;
  logic              win_rd_en;
  logic              win_wr_en;
  rmwf_pkg::sample_t win_rd_data;
  logic              srt_rd_en;
  logic [IW-1:0]     srt_rd_addr;
  rmwf_pkg::sample_t srt_rd_data;
  logic              srt_wr_en;
  logic [IW-1:0]     srt_wr_addr;
  rmwf_pkg::sample_t srt_wr_data;

  assign in_stall   = (state_r != ST_IDLE);
  assign acc        = in_valid && !in_stall;
  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;
  assign out_latest = out_latest_r;

  assign win_rd_en = acc;
  assign win_wr_en = (state_r == ST_OLD);

  rmwf_zmem #(
    .DEPTH (WINDOW),
    .WIDTH (rmwf_pkg::SAMPLE_W)
  ) u_win (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (win_rd_en),
    .rd_addr (pos_r),
    .rd_data (win_rd_data),
    .wr_en   (win_wr_en),
    .wr_addr (pos_r),
    .wr_data (new_r)
  );

  rmwf_zmem #(
    .DEPTH (WINDOW),
    .WIDTH (rmwf_pkg::SAMPLE_W)
  ) u_srt (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (srt_rd_en),
    .rd_addr (srt_rd_addr),
    .rd_data (srt_rd_data),
    .wr_en   (srt_wr_en),
    .wr_addr (srt_wr_addr),
    .wr_data (srt_wr_data)
  );

  // sorted store: drop one copy of the evicted value, then insert the new one
  always_comb begin
    srt_rd_en   = 1'b0;
    srt_rd_addr = '0;
    srt_wr_en   = 1'b0;
    srt_wr_addr = cnt_r;
    srt_wr_data = srt_rd_data;
    unique case (state_r)
      ST_OLD: begin
        srt_rd_en = 1'b1;
      end
      ST_DEL: begin
        srt_rd_en   = (cnt_r != LAST_IDX);
        srt_rd_addr = IW'(cnt_r + 1'b1);
        srt_wr_en   = found_r;
        srt_wr_addr = IW'(cnt_r - 1'b1);
      end
      ST_ISS: begin
        srt_rd_en = 1'b1;
      end
      ST_INS: begin
        srt_rd_en   = (cnt_r != PEN_IDX);
        srt_rd_addr = IW'(cnt_r + 1'b1);
        srt_wr_en   = 1'b1;
        if (ins_r) begin
          srt_wr_data = carry_r;
        end else if (srt_rd_data >= new_r) begin
          srt_wr_data = new_r;
        end
      end
      ST_LAST: begin
        srt_wr_en   = 1'b1;
        srt_wr_addr = LAST_IDX;
        srt_wr_data = ins_r ? carry_r : new_r;
      end
      ST_MED: begin
        srt_rd_en   = 1'b1;
        srt_rd_addr = RANK_IDX;
      end
      ST_IDLE, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      ins_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (acc) begin
            new_r   <= in_sample;
            state_r <= ST_OLD;
          end
        end
        ST_OLD: begin
          old_r   <= win_rd_data;
          pos_r   <= (pos_r == LAST_IDX) ? '0 : IW'(pos_r + 1'b1);
          cnt_r   <= '0;
          found_r <= 1'b0;
          state_r <= ST_DEL;
        end
        ST_DEL: begin
          if (!found_r && srt_rd_data == old_r) begin
            found_r <= 1'b1;
          end
          if (cnt_r == LAST_IDX) begin
            cnt_r   <= '0;
            ins_r   <= 1'b0;
            state_r <= (WINDOW > 1) ? ST_ISS : ST_LAST;
          end else begin
            cnt_r <= IW'(cnt_r + 1'b1);
          end
        end
        ST_ISS: begin
          state_r <= ST_INS;
        end
        ST_INS: begin
          if (ins_r || srt_rd_data >= new_r) begin
            ins_r   <= 1'b1;
            carry_r <= srt_rd_data;
          end
          if (cnt_r == PEN_IDX) begin
            state_r <= ST_LAST;
          end else begin
            cnt_r <= IW'(cnt_r + 1'b1);
          end
        end
        ST_LAST: begin
          state_r <= ST_MED;
        end
        ST_MED: begin
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_median_r <= srt_rd_data;
            out_latest_r <= new_r;
            out_valid_r  <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
